// ===== sv/nss_pkg.sv =====
`default_nettype none

package nss_pkg;

    // Command opcodes
    localparam logic [1:0] OP_TEXT    = 2'd0;
    localparam logic [1:0] OP_PATTERN = 2'd1;
    localparam logic [1:0] OP_SEARCH  = 2'd2;

    // Register indexes on the APB port (paddr[3:2])
    localparam logic [1:0] REG_TEXT_LENGTH    = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [1:0] REG_BASE_OFFSET    = 2'd2;

    localparam int PADDR_W = 4;
    localparam int CMP_W   = 21;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] index;
        logic [7:0]  char_value;
    } nss_cmd_t;

    typedef struct packed {
        logic              found;
        logic [15:0]       position;
        logic [CMP_W-1:0]  comparisons;
    } nss_result_t;

endpackage

`default_nettype wire

// ===== sv/naive_substring_search_core.sv =====
`default_nettype none
// Load words (text or pattern character) give no result.
// Search word: C comparisons run at one per cycle through one byte comparator;
// busy is high while they run, and the result strobe (done) is registered from the
// last comparison (from the accept when the pattern is empty or longer than the text).
// The result is a one-cycle strobe; the receiver cannot stall it.
// Reset (rst_n low, async) resets control and config registers; stores are not cleared.
module naive_substring_search_core
    import nss_pkg::*;
#(
    parameter int TEXT_DEPTH    = 4096,
    parameter int PATTERN_DEPTH = 256
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire nss_cmd_t           cmd,
    // result channel
    output logic                    done,
    output nss_result_t             result,
    // APB configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // Address widths index the stores; count widths hold the depth itself.
    localparam int TAW = $clog2(TEXT_DEPTH);
    localparam int PAW = $clog2(PATTERN_DEPTH);
    localparam int TCW = $clog2(TEXT_DEPTH + 1);
    localparam int PCW = $clog2(PATTERN_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [12:0] text_length_reg;
    logic [8:0]  pattern_length_reg;
    logic [15:0] base_offset_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_length_reg    <= '0;
            pattern_length_reg <= 9'd1;
            base_offset_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_TEXT_LENGTH:    text_length_reg    <= pwdata[12:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[8:0];
                REG_BASE_OFFSET:    base_offset_reg    <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_TEXT_LENGTH:    prdata = {19'd0, text_length_reg};
            REG_PATTERN_LENGTH: prdata = {23'd0, pattern_length_reg};
            REG_BASE_OFFSET:    prdata = {16'd0, base_offset_reg};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Search sequencer
    // ------------------------------------------------------------------
    state_t           state_reg, state_next;
    logic [TCW-1:0]   t_reg, t_next;          // text read pointer
    logic [PCW-1:0]   p_reg, p_next;          // pattern read pointer
    logic [TCW-1:0]   start_reg, start_next;  // current alignment
    logic [TCW-1:0]   lim_reg, lim_next;      // last alignment, n - m
    logic [PCW-1:0]   m_reg, m_next;
    logic [CMP_W-1:0] cmp_reg, cmp_next;
    logic             done_reg, done_next;
    nss_result_t      result_reg, result_next;

    logic [7:0]       text_rd_reg;
    logic [7:0]       pat_rd_reg;
    logic [TCW-1:0]   n_cap;
    logic [PCW-1:0]   m_cap;
    logic             accept;
    logic             chars_eq;
    logic [CMP_W-1:0] cmp_inc;
    logic [TCW:0]     start_inc;
    logic [PCW:0]     p_inc;

    assign accept   = start && !busy;
    assign busy     = (state_reg == ST_RUN);
    assign done     = done_reg;
    assign result   = result_reg;
    assign chars_eq = (text_rd_reg == pat_rd_reg);

    // Cap the programmed lengths at the store depths.
    always_comb
    begin
        if (32'(text_length_reg) > TEXT_DEPTH)
            n_cap = TCW'(TEXT_DEPTH);
        else
            n_cap = TCW'(text_length_reg);
        if (32'(pattern_length_reg) > PATTERN_DEPTH)
            m_cap = PCW'(PATTERN_DEPTH);
        else
            m_cap = PCW'(pattern_length_reg);
    end

    assign start_inc = {1'b0, start_reg} + 1'b1;
    assign p_inc     = {1'b0, p_reg} + 1'b1;
    // Saturate the comparison count at all ones.
    assign cmp_inc   = (&cmp_reg) ? cmp_reg : cmp_reg + 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        t_next      = t_reg;
        p_next      = p_reg;
        start_next  = start_reg;
        lim_next    = lim_reg;
        m_next      = m_reg;
        cmp_next    = cmp_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.op == OP_SEARCH)
                begin
                    t_next     = '0;
                    p_next     = '0;
                    start_next = '0;
                    cmp_next   = '0;
                    m_next     = m_cap;
                    lim_next   = TCW'(32'(n_cap) - 32'(m_cap));
                    if (m_cap == '0)
                    begin
                        // Empty pattern matches at the chunk start.
                        done_next               = 1'b1;
                        result_next.found       = 1'b1;
                        result_next.position    = base_offset_reg;
                        result_next.comparisons = '0;
                    end
                    else if (32'(m_cap) > 32'(n_cap))
                    begin
                        done_next               = 1'b1;
                        result_next.found       = 1'b0;
                        result_next.position    = '0;
                        result_next.comparisons = '0;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // One comparison per cycle; read data matches t_reg / p_reg.
                cmp_next = cmp_inc;
                if (chars_eq)
                begin
                    t_next = t_reg + 1'b1;
                    p_next = p_inc[PCW-1:0];
                    if (p_inc == {1'b0, m_reg})
                    begin
                        state_next              = ST_IDLE;
                        done_next               = 1'b1;
                        result_next.found       = 1'b1;
                        result_next.position    =
                            16'(32'(base_offset_reg) + 32'(start_reg));
                        result_next.comparisons = cmp_inc;
                    end
                end
                else
                begin
                    // Slide the alignment one place and restart the pattern.
                    start_next = start_inc[TCW-1:0];
                    t_next     = start_inc[TCW-1:0];
                    p_next     = '0;
                    if (start_inc > {1'b0, lim_reg})
                    begin
                        state_next              = ST_IDLE;
                        done_next               = 1'b1;
                        result_next.found       = 1'b0;
                        result_next.position    = '0;
                        result_next.comparisons = cmp_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        p_reg      <= p_next;
        start_reg  <= start_next;
        lim_reg    <= lim_next;
        m_reg      <= m_next;
        cmp_reg    <= cmp_next;
        result_reg <= result_next;
    end

    // ------------------------------------------------------------------
    // Character stores: written by load words, read at the next pointers
    // so the data for the current pointers is ready each cycle.
    // ------------------------------------------------------------------
    logic [7:0] text_mem [TEXT_DEPTH];
    logic [7:0] pat_mem  [PATTERN_DEPTH];

    always_ff @(posedge clk)
    begin
        if (accept && cmd.op == OP_TEXT && 32'(cmd.index) < TEXT_DEPTH)
            text_mem[TAW'(cmd.index)] <= cmd.char_value;
        text_rd_reg <= text_mem[t_next[TAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.op == OP_PATTERN && 32'(cmd.index) < PATTERN_DEPTH)
            pat_mem[PAW'(cmd.index)] <= cmd.char_value;
        pat_rd_reg <= pat_mem[p_next[PAW-1:0]];
    end

endmodule

`default_nettype wire

// ===== sv/nss_checker.sv =====
`default_nettype none

module nss_checker
    import nss_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire nss_cmd_t    cmd,
    input wire logic        done,
    input wire nss_result_t result,
    input wire logic        pready
);

    // The APB port never inserts wait states.
    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // A result word is shown only once the search has finished.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // A miss reports position zero.
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.position == 16'd0))
        else $error("miss with nonzero position");

    // Busy starts only after an accepted search word.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && cmd.op == OP_SEARCH))
        else $error("busy without search");

    // Load and unused words give no result.
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.op != OP_SEARCH) |=> !done)
        else $error("result after non-search word");

endmodule

bind naive_substring_search_core nss_checker u_nss_checker (.*);

`default_nettype wire
